[hw/rtl/mbq_pkg.sv]
// Shared types and constants for the multichannel biquad.
// Holds the register map, the structure codes, the channel row layout and the
// micro-step encoding used by the sequencer. No dependencies.
package mbq_pkg;

    localparam int CHAN_BITS  = 3;
    localparam int ADDR_BITS  = 3;
    localparam int STATE_BITS = 48;
    localparam int STATE_FRAC = 40;
    localparam int ACC_BITS   = 56;

    // Configuration register indexes
    localparam logic [ADDR_BITS-1:0] REG_B0   = 3'd0;
    localparam logic [ADDR_BITS-1:0] REG_B1   = 3'd1;
    localparam logic [ADDR_BITS-1:0] REG_B2   = 3'd2;
    localparam logic [ADDR_BITS-1:0] REG_A1   = 3'd3;
    localparam logic [ADDR_BITS-1:0] REG_A2   = 3'd4;
    localparam logic [ADDR_BITS-1:0] REG_MODE = 3'd5;

    typedef enum logic [1:0] {
        FORM_DF1  = 2'd0,
        FORM_DF2  = 2'd1,
        FORM_TDF1 = 2'd2,
        FORM_TDF2 = 2'd3
    } form_t;

    typedef logic signed [STATE_BITS-1:0] state_word_t;

    // One channel's delay state, one RAM word
    typedef struct packed {
        state_word_t w1;
        state_word_t w2;
        state_word_t x1;
        state_word_t x2;
        state_word_t y1;
        state_word_t y2;
    } row_t;

    typedef enum logic [3:0] {
        OP_X, OP_XD1, OP_XD2, OP_YD1, OP_YD2, OP_WD1, OP_WD2, OP_T, OP_Y
    } operand_t;

    typedef enum logic [2:0] {
        CF_B0, CF_B1, CF_B2, CF_A1, CF_A2
    } coef_sel_t;

    typedef enum logic [2:0] {
        AD_ZERO, AD_X, AD_XD1, AD_XD2, AD_WD1, AD_WD2
    } addend_t;

    typedef enum logic [2:0] {
        D_T, D_Y, D_A, D_B, D_C, D_D
    } dest_t;

    // One micro-step: optional product term added to the running sum
    typedef struct packed {
        logic      mul;
        operand_t  op;
        coef_sel_t cf;
        addend_t   ad;
        logic      first;
        logic      last;
        dest_t     dst;
        logic      done;
    } step_t;

endpackage

[hw/rtl/mbq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the per-channel delay state. No dependencies.
module mbq_ram #(
    parameter int WIDTH = 288,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[hw/rtl/multichannel_biquad_four_forms.sv]
// Multichannel biquad, four selectable structures, top level.
// Depends on mbq_pkg (types, codes) and mbq_ram (delay state storage).
//
//  port group   dir   handshake          payload
//  s_*          in    s_valid/s_ready    s_chan, s_sample_in
//  m_*          out   m_valid/m_ready    m_chan_out, m_sample_out
//  cfg_*        in    cfg_wr_en          cfg_addr, cfg_wdata
//
// One word at a time: accept, RAM read, then the shared multiplier runs a
// low-half, a high-half and an accumulate step per product term and only the
// accumulate step per plain add, then write-back. The next word is accepted
// once the machine is back in idle after write-back. The multiplier is a
// single 25xCOEF unit. Reset is synchronous; state reads as zero afterwards.
// A stalled result holds in the output register and blocks only the
// write-back of the next word.
module multichannel_biquad_four_forms #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mbq_pkg::CHAN_BITS-1:0]        s_chan,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mbq_pkg::CHAN_BITS-1:0]        m_chan_out,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out,

    input  logic                                 cfg_wr_en,
    input  logic [mbq_pkg::ADDR_BITS-1:0]        cfg_addr,
    input  logic [COEF_BITS-1:0]                 cfg_wdata
);

    localparam int SB        = mbq_pkg::STATE_BITS;
    localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IO_SHIFT  = mbq_pkg::STATE_FRAC - (SAMPLE_BITS - 1);
    localparam int COEF_FRAC = COEF_BITS - 3;
    localparam int PW        = SB + COEF_BITS + 1;
    localparam int AB        = mbq_pkg::ACC_BITS;
    localparam int RW        = $bits(mbq_pkg::row_t);
    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(64'sd1 <<< COEF_FRAC);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_RUN, S_WB} fsm_t;

    fsm_t                          state_reg, state_next;
    logic signed [COEF_BITS-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    mbq_pkg::form_t                mode_reg;
    logic [CHANNELS-1:0]           vld_reg, vld_next;
    logic [AW-1:0]                 k_reg, k_next;
    logic [mbq_pkg::CHAN_BITS-1:0] chan_reg, chan_next;
    mbq_pkg::state_word_t          x_reg, x_next;
    mbq_pkg::row_t                 row_reg, row_next;
    logic [2:0]                    idx_reg, idx_next;
    logic [1:0]                    ph_reg, ph_next;
    logic signed [COEF_BITS+24:0]  lo_reg, lo_next;
    logic signed [COEF_BITS+23:0]  hi_reg, hi_next;
    logic signed [AB-1:0]          acc_reg, acc_next;
    mbq_pkg::state_word_t          t_reg, t_next, y_reg, y_next;
    mbq_pkg::state_word_t          ra_reg, ra_next, rb_reg, rb_next;
    mbq_pkg::state_word_t          rc_reg, rc_next, rd_reg, rd_next;
    logic                          m_valid_reg, m_valid_next;
    logic [mbq_pkg::CHAN_BITS-1:0] m_chan_reg, m_chan_next;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg, m_sample_next;

    logic                          ram_we;
    logic [RW-1:0]                 ram_rdata;
    mbq_pkg::row_t                 row_wb;
    mbq_pkg::step_t                stp;
    mbq_pkg::state_word_t          opnd;
    logic signed [COEF_BITS-1:0]   coef;
    mbq_pkg::state_word_t          addend;
    logic signed [24:0]            mul_a;
    logic signed [COEF_BITS+24:0]  mul_p;
    logic signed [PW-1:0]          full_prod;
    logic signed [AB-1:0]          term, acc_sum;
    mbq_pkg::state_word_t          acc_sat;
    mbq_pkg::state_word_t          y_shift;
    logic                          out_free;
    logic                          mode_clear;

    function automatic logic [AW-1:0] chan_mod(input logic [mbq_pkg::CHAN_BITS-1:0] c);
        logic [mbq_pkg::CHAN_BITS:0] v;
        v = {1'b0, c};
        for (int i = 0; i < 8; i++) begin
            if (32'(v) >= CHANNELS) begin
                v = v - (mbq_pkg::CHAN_BITS+1)'(CHANNELS);
            end
        end
        return AW'(v);
    endfunction

    function automatic mbq_pkg::step_t mk(
        input logic mul, input mbq_pkg::operand_t op, input mbq_pkg::coef_sel_t cf,
        input mbq_pkg::addend_t ad, input logic first, input logic last,
        input mbq_pkg::dest_t dst, input logic done);
        mbq_pkg::step_t s;
        s.mul   = mul;
        s.op    = op;
        s.cf    = cf;
        s.ad    = ad;
        s.first = first;
        s.last  = last;
        s.dst   = dst;
        s.done  = done;
        return s;
    endfunction

    // Micro-program of each structure
    function automatic mbq_pkg::step_t prog(input mbq_pkg::form_t m, input logic [2:0] i);
        mbq_pkg::step_t s;
        s = mk(1'b0, mbq_pkg::OP_X, mbq_pkg::CF_B0, mbq_pkg::AD_ZERO, 1'b1, 1'b1,
               mbq_pkg::D_Y, 1'b1);
        case (m)
            mbq_pkg::FORM_DF1: begin
                case (i)
                    3'd0: s = mk(1'b1, mbq_pkg::OP_X, mbq_pkg::CF_B0, mbq_pkg::AD_ZERO,
                                 1'b1, 1'b0, mbq_pkg::D_Y, 1'b0);
                    3'd1: s = mk(1'b1, mbq_pkg::OP_XD1, mbq_pkg::CF_B1, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b0, mbq_pkg::D_Y, 1'b0);
                    3'd2: s = mk(1'b1, mbq_pkg::OP_XD2, mbq_pkg::CF_B2, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b0, mbq_pkg::D_Y, 1'b0);
                    3'd3: s = mk(1'b1, mbq_pkg::OP_YD1, mbq_pkg::CF_A1, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b0, mbq_pkg::D_Y, 1'b0);
                    3'd4: s = mk(1'b1, mbq_pkg::OP_YD2, mbq_pkg::CF_A2, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b1, mbq_pkg::D_Y, 1'b1);
                    default: ;
                endcase
            end
            mbq_pkg::FORM_DF2: begin
                case (i)
                    3'd0: s = mk(1'b1, mbq_pkg::OP_WD1, mbq_pkg::CF_A1, mbq_pkg::AD_X,
                                 1'b1, 1'b0, mbq_pkg::D_T, 1'b0);
                    3'd1: s = mk(1'b1, mbq_pkg::OP_WD2, mbq_pkg::CF_A2, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b1, mbq_pkg::D_T, 1'b0);
                    3'd2: s = mk(1'b1, mbq_pkg::OP_T, mbq_pkg::CF_B0, mbq_pkg::AD_ZERO,
                                 1'b1, 1'b0, mbq_pkg::D_Y, 1'b0);
                    3'd3: s = mk(1'b1, mbq_pkg::OP_WD1, mbq_pkg::CF_B1, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b0, mbq_pkg::D_Y, 1'b0);
                    3'd4: s = mk(1'b1, mbq_pkg::OP_WD2, mbq_pkg::CF_B2, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b1, mbq_pkg::D_Y, 1'b1);
                    default: ;
                endcase
            end
            mbq_pkg::FORM_TDF1: begin
                case (i)
                    3'd0: s = mk(1'b0, mbq_pkg::OP_WD2, mbq_pkg::CF_B0, mbq_pkg::AD_X,
                                 1'b1, 1'b1, mbq_pkg::D_T, 1'b0);
                    3'd1: s = mk(1'b1, mbq_pkg::OP_T, mbq_pkg::CF_B0, mbq_pkg::AD_XD2,
                                 1'b1, 1'b1, mbq_pkg::D_Y, 1'b0);
                    3'd2: s = mk(1'b1, mbq_pkg::OP_T, mbq_pkg::CF_B1, mbq_pkg::AD_XD1,
                                 1'b1, 1'b1, mbq_pkg::D_A, 1'b0);
                    3'd3: s = mk(1'b1, mbq_pkg::OP_T, mbq_pkg::CF_A1, mbq_pkg::AD_WD1,
                                 1'b1, 1'b1, mbq_pkg::D_B, 1'b0);
                    3'd4: s = mk(1'b1, mbq_pkg::OP_T, mbq_pkg::CF_B2, mbq_pkg::AD_ZERO,
                                 1'b1, 1'b1, mbq_pkg::D_C, 1'b0);
                    3'd5: s = mk(1'b1, mbq_pkg::OP_T, mbq_pkg::CF_A2, mbq_pkg::AD_ZERO,
                                 1'b1, 1'b1, mbq_pkg::D_D, 1'b1);
                    default: ;
                endcase
            end
            default: begin
                case (i)
                    3'd0: s = mk(1'b1, mbq_pkg::OP_X, mbq_pkg::CF_B0, mbq_pkg::AD_XD2,
                                 1'b1, 1'b1, mbq_pkg::D_Y, 1'b0);
                    3'd1: s = mk(1'b1, mbq_pkg::OP_X, mbq_pkg::CF_B1, mbq_pkg::AD_XD1,
                                 1'b1, 1'b0, mbq_pkg::D_A, 1'b0);
                    3'd2: s = mk(1'b1, mbq_pkg::OP_Y, mbq_pkg::CF_A1, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b1, mbq_pkg::D_A, 1'b0);
                    3'd3: s = mk(1'b1, mbq_pkg::OP_X, mbq_pkg::CF_B2, mbq_pkg::AD_ZERO,
                                 1'b1, 1'b0, mbq_pkg::D_B, 1'b0);
                    3'd4: s = mk(1'b1, mbq_pkg::OP_Y, mbq_pkg::CF_A2, mbq_pkg::AD_ZERO,
                                 1'b0, 1'b1, mbq_pkg::D_B, 1'b1);
                    default: ;
                endcase
            end
        endcase
        return s;
    endfunction

    mbq_ram #(
        .WIDTH(RW),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(k_reg),
        .wdata(row_wb),
        .raddr(chan_mod(s_chan)),
        .rdata(ram_rdata)
    );

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_chan_out   = m_chan_reg;
    assign m_sample_out = m_sample_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign ram_we       = (state_reg == S_WB) && out_free;
    assign mode_clear   = cfg_wr_en && (cfg_addr == mbq_pkg::REG_MODE) &&
                          (cfg_wdata[1:0] != mode_reg);

    // Datapath of the shared multiply-accumulate
    always_comb begin
        stp = prog(mode_reg, idx_reg);
        case (stp.op)
            mbq_pkg::OP_X:   opnd = x_reg;
            mbq_pkg::OP_XD1: opnd = row_reg.x1;
            mbq_pkg::OP_XD2: opnd = row_reg.x2;
            mbq_pkg::OP_YD1: opnd = row_reg.y1;
            mbq_pkg::OP_YD2: opnd = row_reg.y2;
            mbq_pkg::OP_WD1: opnd = row_reg.w1;
            mbq_pkg::OP_WD2: opnd = row_reg.w2;
            mbq_pkg::OP_T:   opnd = t_reg;
            mbq_pkg::OP_Y:   opnd = y_reg;
            default:         opnd = '0;
        endcase
        case (stp.cf)
            mbq_pkg::CF_B0: coef = b0_reg;
            mbq_pkg::CF_B1: coef = b1_reg;
            mbq_pkg::CF_B2: coef = b2_reg;
            mbq_pkg::CF_A1: coef = a1_reg;
            mbq_pkg::CF_A2: coef = a2_reg;
            default:        coef = '0;
        endcase
        case (stp.ad)
            mbq_pkg::AD_X:   addend = x_reg;
            mbq_pkg::AD_XD1: addend = row_reg.x1;
            mbq_pkg::AD_XD2: addend = row_reg.x2;
            mbq_pkg::AD_WD1: addend = row_reg.w1;
            mbq_pkg::AD_WD2: addend = row_reg.w2;
            default:         addend = '0;
        endcase
        // Low half unsigned first, signed high half next
        mul_a     = (ph_reg == 2'd0) ? $signed({1'b0, opnd[23:0]}) :
                                       $signed({opnd[SB-1], opnd[SB-1:24]});
        mul_p     = mul_a * coef;
        full_prod = (PW'(hi_reg) <<< 24) + PW'(lo_reg);
        term      = stp.mul ? AB'(full_prod >>> COEF_FRAC) : AB'(opnd);
        acc_sum   = (stp.first ? AB'(addend) : acc_reg) + term;
        if ((acc_sum[AB-1:SB-1] == '0) || (acc_sum[AB-1:SB-1] == '1)) begin
            acc_sat = acc_sum[SB-1:0];
        end else if (acc_sum[AB-1]) begin
            acc_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // New channel row per structure
    always_comb begin
        row_wb = row_reg;
        case (mode_reg)
            mbq_pkg::FORM_DF1: begin
                row_wb.x2 = row_reg.x1;
                row_wb.x1 = x_reg;
                row_wb.y2 = row_reg.y1;
                row_wb.y1 = y_reg;
            end
            mbq_pkg::FORM_DF2: begin
                row_wb.w2 = row_reg.w1;
                row_wb.w1 = t_reg;
            end
            mbq_pkg::FORM_TDF1: begin
                row_wb.x2 = ra_reg;
                row_wb.w2 = rb_reg;
                row_wb.x1 = rc_reg;
                row_wb.w1 = rd_reg;
            end
            default: begin
                row_wb.x2 = ra_reg;
                row_wb.x1 = rb_reg;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        vld_next      = vld_reg;
        k_next        = k_reg;
        chan_next     = chan_reg;
        x_next        = x_reg;
        row_next      = row_reg;
        idx_next      = idx_reg;
        ph_next       = ph_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        acc_next      = acc_reg;
        t_next        = t_reg;
        y_next        = y_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        rc_next       = rc_reg;
        rd_next       = rd_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_chan_next   = m_chan_reg;
        m_sample_next = m_sample_reg;
        y_shift       = y_reg >>> IO_SHIFT;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    k_next     = chan_mod(s_chan);
                    chan_next  = s_chan;
                    x_next     = {{(SB-SAMPLE_BITS-IO_SHIFT){s_sample_in[SAMPLE_BITS-1]}},
                                  s_sample_in, {IO_SHIFT{1'b0}}};
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // A row never written since reset or a mode change reads as zero
                row_next   = vld_reg[k_reg] ? mbq_pkg::row_t'(ram_rdata) : '0;
                idx_next   = '0;
                ph_next    = '0;
                state_next = S_RUN;
            end
            S_RUN: begin
                if (stp.mul && (ph_reg == 2'd0)) begin
                    lo_next = mul_p;
                    ph_next = 2'd1;
                end else if (stp.mul && (ph_reg == 2'd1)) begin
                    hi_next = mul_p[COEF_BITS+23:0];
                    ph_next = 2'd2;
                end else begin
                    acc_next = acc_sum;
                    ph_next  = 2'd0;
                    if (stp.last) begin
                        case (stp.dst)
                            mbq_pkg::D_T: t_next  = acc_sat;
                            mbq_pkg::D_Y: y_next  = acc_sat;
                            mbq_pkg::D_A: ra_next = acc_sat;
                            mbq_pkg::D_B: rb_next = acc_sat;
                            mbq_pkg::D_C: rc_next = acc_sat;
                            default:      rd_next = acc_sat;
                        endcase
                    end
                    if (stp.done) begin
                        state_next = S_WB;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            S_WB: begin
                if (out_free) begin
                    vld_next[k_reg] = 1'b1;
                    m_valid_next    = 1'b1;
                    m_chan_next     = chan_reg;
                    if ((y_shift[SB-1:SAMPLE_BITS-1] == '0) ||
                        (y_shift[SB-1:SAMPLE_BITS-1] == '1)) begin
                        m_sample_next = y_shift[SAMPLE_BITS-1:0];
                    end else if (y_shift[SB-1]) begin
                        m_sample_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    end else begin
                        m_sample_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (mode_clear) begin
            vld_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            b0_reg      <= COEF_ONE;
            b1_reg      <= '0;
            b2_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
            mode_reg    <= mbq_pkg::FORM_TDF2;
            idx_reg     <= '0;
            ph_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            vld_reg     <= vld_next;
            idx_reg     <= idx_next;
            ph_reg      <= ph_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    mbq_pkg::REG_B0:   b0_reg   <= cfg_wdata;
                    mbq_pkg::REG_B1:   b1_reg   <= cfg_wdata;
                    mbq_pkg::REG_B2:   b2_reg   <= cfg_wdata;
                    mbq_pkg::REG_A1:   a1_reg   <= cfg_wdata;
                    mbq_pkg::REG_A2:   a2_reg   <= cfg_wdata;
                    mbq_pkg::REG_MODE: mode_reg <= mbq_pkg::form_t'(cfg_wdata[1:0]);
                    default: ;
                endcase
            end
        end
        k_reg        <= k_next;
        chan_reg     <= chan_next;
        x_reg        <= x_next;
        row_reg      <= row_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        t_reg        <= t_next;
        y_reg        <= y_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rc_reg       <= rc_next;
        rd_reg       <= rd_next;
        m_chan_reg   <= m_chan_next;
        m_sample_reg <= m_sample_next;
    end

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_READ && !s_ready))
        else $error("accepted word did not start a state read");

    a_wb_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WB && out_free) |=> (m_valid && m_chan_out == $past(chan_reg)))
        else $error("write-back did not present the result");

    a_mode_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_clear |=> (vld_reg == '0))
        else $error("structure change left channel state valid");

    a_ram_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (state_reg == S_IDLE))
        else $error("state written back without finishing the word");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for multichannel_biquad_four_forms.
// Drives random and directed words through all four filter structures and
// checks each result against an in-bench fixed-point biquad; needs mbq_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam int NCH = 8;
    localparam int SBITS = 24;
    localparam int CBITS = 32;
    localparam int IO_SHIFT = mbq_pkg::STATE_FRAC - (SBITS - 1);
    localparam int CFRAC = CBITS - 3;

    typedef logic signed [79:0] wide_t;
    typedef logic signed [CBITS-1:0] coef_t;

    typedef struct {
        logic [mbq_pkg::CHAN_BITS-1:0] chan;
        logic signed [SBITS-1:0] sample;
    } word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [mbq_pkg::CHAN_BITS-1:0] s_chan = '0;
    logic signed [SBITS-1:0] s_sample_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [mbq_pkg::CHAN_BITS-1:0] m_chan_out;
    logic signed [SBITS-1:0] m_sample_out;
    logic cfg_wr_en = 1'b0;
    logic [mbq_pkg::ADDR_BITS-1:0] cfg_addr = '0;
    logic [CBITS-1:0] cfg_wdata = '0;

    word_t pending_words[$];
    word_t expected_outputs[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_cnt = 0;

    // predictor state
    coef_t k_b0, k_b1, k_b2, k_a1, k_a2;
    mbq_pkg::form_t k_form;
    mbq_pkg::state_word_t wd1[NCH], wd2[NCH], xd1[NCH], xd2[NCH], yd1[NCH], yd2[NCH];

    multichannel_biquad_four_forms #(
        .CHANNELS(NCH), .SAMPLE_BITS(SBITS), .COEF_BITS(CBITS)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_chan(s_chan), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_chan_out(m_chan_out),
        .m_sample_out(m_sample_out),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // floor(a * c / 2^CFRAC), exact
    function automatic wide_t scale(mbq_pkg::state_word_t a, coef_t c);
        wide_t wa;
        wide_t wc;
        wa = a;
        wc = c;
        return (wa * wc) >>> CFRAC;
    endfunction

    function automatic mbq_pkg::state_word_t clip48(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (mbq_pkg::STATE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[mbq_pkg::STATE_BITS-1:0];
        if (v < lo) return lo[mbq_pkg::STATE_BITS-1:0];
        return v[mbq_pkg::STATE_BITS-1:0];
    endfunction

    function automatic void clear_delays();
        for (int i = 0; i < NCH; i++) begin
            wd1[i] = '0; wd2[i] = '0; xd1[i] = '0;
            xd2[i] = '0; yd1[i] = '0; yd2[i] = '0;
        end
    endfunction

    function automatic logic signed [SBITS-1:0] filter_predict(word_t w);
        int k;
        mbq_pkg::state_word_t x, y, v;
        wide_t o;
        wide_t hi;
        k = w.chan % NCH;
        x = mbq_pkg::state_word_t'(w.sample) <<< IO_SHIFT;
        case (k_form)
            mbq_pkg::FORM_DF1: begin
                y = clip48(scale(x, k_b0) + scale(xd1[k], k_b1) + scale(xd2[k], k_b2)
                           + scale(yd1[k], k_a1) + scale(yd2[k], k_a2));
                xd2[k] = xd1[k]; yd2[k] = yd1[k];
                xd1[k] = x; yd1[k] = y;
            end
            mbq_pkg::FORM_DF2: begin
                v = clip48(wide_t'(x) + scale(wd1[k], k_a1) + scale(wd2[k], k_a2));
                y = clip48(scale(v, k_b0) + scale(wd1[k], k_b1) + scale(wd2[k], k_b2));
                wd2[k] = wd1[k]; wd1[k] = v;
            end
            mbq_pkg::FORM_TDF1: begin
                v = clip48(wide_t'(x) + wide_t'(wd2[k]));
                y = clip48(scale(v, k_b0) + wide_t'(xd2[k]));
                xd2[k] = clip48(scale(v, k_b1) + wide_t'(xd1[k]));
                wd2[k] = clip48(scale(v, k_a1) + wide_t'(wd1[k]));
                xd1[k] = clip48(scale(v, k_b2));
                wd1[k] = clip48(scale(v, k_a2));
            end
            default: begin
                y = clip48(scale(x, k_b0) + wide_t'(xd2[k]));
                xd2[k] = clip48(scale(x, k_b1) + wide_t'(xd1[k]) + scale(y, k_a1));
                xd1[k] = clip48(scale(x, k_b2) + scale(y, k_a2));
            end
        endcase
        o = wide_t'(y) >>> IO_SHIFT;
        hi = (wide_t'(1) <<< (SBITS - 1)) - 1;
        if (o > hi) o = hi;
        if (o < -hi - 1) o = -hi - 1;
        return o[SBITS-1:0];
    endfunction

    function automatic void model_write(logic [mbq_pkg::ADDR_BITS-1:0] idx,
                                        logic [CBITS-1:0] val);
        case (idx)
            mbq_pkg::REG_B0: k_b0 = val;
            mbq_pkg::REG_B1: k_b1 = val;
            mbq_pkg::REG_B2: k_b2 = val;
            mbq_pkg::REG_A1: k_a1 = val;
            mbq_pkg::REG_A2: k_a2 = val;
            mbq_pkg::REG_MODE: begin
                if (mbq_pkg::form_t'(val[1:0]) != k_form) begin
                    k_form = mbq_pkg::form_t'(val[1:0]);
                    clear_delays();
                end
            end
            default: ;
        endcase
    endfunction

    // driver: pop the accepted word, then offer the next one or idle
    always @(posedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                expected_outputs.push_back('{pending_words[0].chan,
                                             filter_predict(pending_words[0])});
                void'(pending_words.pop_front());
                nv = 1'b0;
            end
            if (!nv && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nv = 1'b1;
                s_chan <= pending_words[0].chan;
                s_sample_in <= pending_words[0].sample;
            end
            s_valid <= nv;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_cnt <= hold_len;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected word chan=%0d sample=%0d", $time,
                         m_chan_out, m_sample_out);
                fail_count++;
            end else begin
                e = expected_outputs.pop_front();
                if (m_chan_out !== e.chan) begin
                    $display("%0t: chan_out expected %0d actual %0d", $time, e.chan,
                             m_chan_out);
                    fail_count++;
                end
                if (m_sample_out !== e.sample) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time, e.sample,
                             m_sample_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_outputs.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic reg_write(logic [mbq_pkg::ADDR_BITS-1:0] idx, logic [CBITS-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        model_write(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic coef_t pick_coef(int style, int span);
        case (style == 0 ? $urandom_range(3) : 4)
            0: return coef_t'(32'h8000_0000);
            1: return coef_t'(32'h7fff_ffff);
            2: return '0;
            3: return coef_t'($urandom);
            default: return coef_t'(int'($urandom_range(2 * span - 1)) - span);
        endcase
    endfunction

    function automatic word_t rand_word();
        word_t w;
        w.chan = mbq_pkg::CHAN_BITS'($urandom_range(7));
        case ($urandom_range(5))
            0: w.sample = {1'b1, {(SBITS-1){1'b0}}};
            1: w.sample = {1'b0, {(SBITS-1){1'b1}}};
            2: w.sample = SBITS'(int'($urandom_range(8191)) - 4096);
            default: w.sample = SBITS'($urandom);
        endcase
        return w;
    endfunction

    initial begin
        int style;
        logic [1:0] mode;
        k_b0 = coef_t'(1) <<< CFRAC;
        k_b1 = '0; k_b2 = '0; k_a1 = '0; k_a2 = '0;
        k_form = mbq_pkg::FORM_TDF2;
        clear_delays();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every channel, sample extremes, reset coefficients
        for (int c = 0; c < NCH; c++)
            pending_words.push_back('{c[mbq_pkg::CHAN_BITS-1:0],
                                      (c % 2) ? 24'sh7fffff : 24'sh800000});
        pending_words.push_back('{3'd0, 24'sd0});
        pending_words.push_back('{3'd7, -24'sd1});
        drain();
        // extreme coefficients, same mode rewritten, unknown indexes
        reg_write(mbq_pkg::REG_B0, 32'h7fff_ffff);
        reg_write(mbq_pkg::REG_B1, 32'h8000_0000);
        reg_write(mbq_pkg::REG_A1, 32'h7fff_ffff);
        reg_write(mbq_pkg::REG_A2, 32'h8000_0000);
        reg_write(mbq_pkg::REG_MODE, 32'hffff_fffb);
        reg_write(3'd6, 32'h1234_5678);
        reg_write(3'd7, 32'hffff_ffff);
        for (int i = 0; i < 12; i++)
            pending_words.push_back('{i[mbq_pkg::CHAN_BITS-1:0] & 3'd1,
                                      (i % 3 == 0) ? 24'sh7fffff : 24'sh800000});
        drain();

        for (int p = 0; p < 12; p++) begin
            style = p % 3;
            mode = p[1:0];
            reg_write(mbq_pkg::REG_B0, pick_coef(style, 1 << 29));
            reg_write(mbq_pkg::REG_B1, pick_coef(style, 1 << 28));
            reg_write(mbq_pkg::REG_B2, pick_coef(style, 1 << 28));
            reg_write(mbq_pkg::REG_A1, pick_coef(style, 1 << 29));
            reg_write(mbq_pkg::REG_A2, pick_coef(style, 1 << 27));
            reg_write(mbq_pkg::REG_MODE, CBITS'({$urandom, mode}));
            if (p == 6) reg_write(mbq_pkg::REG_MODE, CBITS'({$urandom, mode}));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (p == 4 || p == 9) begin
                // stall the result side long enough to back up the input
                hold_len = 400;
                hold_token++;
            end
            for (int i = 0; i < 38; i++)
                pending_words.push_back(rand_word());
            // sender pauses here until every result is back
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
